[rtl/fed_pkg.sv]
// Shared widths, register indexes and constants of the feedback echo delay.
`timescale 1ns / 1ps
`default_nettype none
package fed_pkg;

  localparam int unsigned MemDepth = 32768;
  localparam int unsigned PtrW     = $clog2(MemDepth);
  localparam int unsigned SampleW  = 16;
  localparam int unsigned DecayW   = 16;
  localparam int unsigned DelayW   = 20;
  localparam int unsigned LenW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [PtrW-1:0]    ptr_t;

  localparam cfg_idx_t CfgDecay  = 2'd0;
  localparam cfg_idx_t CfgDelay  = 2'd1;
  localparam cfg_idx_t CfgLength = 2'd2;

  localparam logic [DecayW-1:0] DecayOne   = 16'd32768;
  localparam logic [DecayW-1:0] DecayReset = 16'd16384;
  localparam logic [DelayW-1:0] DelayReset = 20'd8000;
  localparam logic [LenW-1:0]   LenReset   = 16'd32768;
  localparam logic [DelayW-1:0] CountMax   = '1;

endpackage
`default_nettype wire

[rtl/fed_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fed_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // a read in the cycle of a write to the same entry returns the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/feedback_echo_delay.sv]
// Pipeline: an accepted sample passes stage 1 (read in flight), stage 2 (product registered) and the output register.
// Throughput: one sample per cycle while the output is not stalled; a read of an entry
// whose write is still in the pipeline holds off acceptance until that write lands, which
// a stalled output puts off further (only with a very short delay or buffer length).
// Reset: registers return to their defaults, pointers and the sample count clear,
// echo switches off; delay memory contents stay undefined and get no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module feedback_echo_delay (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fed_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [fed_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                sample_in_valid_i,
  output logic                                sample_in_ready_o,
  input  logic signed [fed_pkg::SampleW-1:0]  sample_in_i,
  output logic                                sample_out_valid_o,
  input  logic                                sample_out_ready_i,
  output logic signed [fed_pkg::SampleW-1:0]  sample_out_o
);

  localparam int unsigned CmpW =
      (fed_pkg::LenW > fed_pkg::PtrW + 1) ? fed_pkg::LenW : fed_pkg::PtrW + 1;
  localparam int unsigned ProdW = 2 * fed_pkg::SampleW + 2;

  function automatic fed_pkg::ptr_t advance(fed_pkg::ptr_t p,
                                            logic [fed_pkg::LenW-1:0] len);
    logic [CmpW-1:0] n;
    n = CmpW'(p) + CmpW'(1);
    if ((n >= CmpW'(len)) || (n >= CmpW'(fed_pkg::MemDepth))) begin
      return '0;
    end
    return fed_pkg::PtrW'(n);
  endfunction

  // configuration
  logic [fed_pkg::DecayW-1:0] decay_q;
  logic [fed_pkg::DelayW-1:0] delay_q;
  logic [fed_pkg::LenW-1:0]   length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q  <= fed_pkg::DecayReset;
      delay_q  <= fed_pkg::DelayReset;
      length_q <= fed_pkg::LenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fed_pkg::CfgDecay:  decay_q  <= cfg_data_i[fed_pkg::DecayW-1:0];
        fed_pkg::CfgDelay:  delay_q  <= cfg_data_i[fed_pkg::DelayW-1:0];
        fed_pkg::CfgLength: length_q <= cfg_data_i[fed_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // pointers and echo control
  fed_pkg::ptr_t              wp_q, rp_q;
  logic [fed_pkg::DelayW-1:0] count_q;
  logic                       echo_q;

  // stage 1: read in flight
  logic                               v1_q, echo1_q;
  logic signed [fed_pkg::SampleW-1:0] x1_q;
  fed_pkg::ptr_t                      wp1_q;
  // stage 2: product registered
  logic                               v2_q, echo2_q;
  logic signed [fed_pkg::SampleW-1:0] x2_q;
  fed_pkg::ptr_t                      wp2_q;
  logic signed [ProdW-1:0]            p2_q;
  // output register
  logic                               out_v_q;
  logic signed [fed_pkg::SampleW-1:0] out_q;

  logic echo_now, hazard, en_out, en2, en1, acc, wr_en;
  logic [fed_pkg::SampleW-1:0]        rdata;
  logic [fed_pkg::DecayW-1:0]         gain_sat;
  logic signed [fed_pkg::SampleW:0]   diff;
  logic signed [fed_pkg::SampleW+1:0] gain_s;
  logic signed [ProdW-1:0]            prod;
  logic signed [ProdW-1:0]            sum, biased;
  logic signed [fed_pkg::SampleW-1:0] y;

  assign echo_now = echo_q || (count_q >= delay_q);
  // hold off a read of an entry whose write is still in the pipeline
  assign hazard = echo_now && ((v1_q && (rp_q == wp1_q)) || (v2_q && (rp_q == wp2_q)));

  assign en_out = !out_v_q || sample_out_ready_i;
  assign en2    = !v2_q || en_out;
  assign en1    = !v1_q || en2;
  assign sample_in_ready_o = en1 && !hazard;
  assign acc    = sample_in_valid_i && sample_in_ready_o;
  assign wr_en  = v2_q && en_out;

  fed_ram #(
    .Width (fed_pkg::SampleW),
    .Depth (fed_pkg::MemDepth)
  ) u_fed_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp2_q),
    .wdata_i (y),
    .re_i    (acc),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  // (1 - g) * x + g * d  =  x * 2^15 + g * (d - x)
  assign gain_sat = (decay_q > fed_pkg::DecayOne) ? fed_pkg::DecayOne : decay_q;
  assign gain_s   = {2'b00, gain_sat};
  assign diff     = {rdata[fed_pkg::SampleW-1], rdata} - {x1_q[fed_pkg::SampleW-1], x1_q};
  assign prod     = ProdW'(gain_s) * ProdW'(diff);

  assign sum    = {{(ProdW - fed_pkg::SampleW - 15){x2_q[fed_pkg::SampleW-1]}}, x2_q, 15'b0}
                  + p2_q;
  // bias negative sums so the shift truncates toward zero
  assign biased = sum + (sum[ProdW-1] ? ProdW'(32767) : ProdW'(0));
  assign y      = echo2_q ? biased[15 +: fed_pkg::SampleW] : x2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
      echo_q  <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (acc) begin
        wp_q   <= advance(wp_q, length_q);
        echo_q <= echo_now;
        if (echo_now) begin
          rp_q <= advance(rp_q, length_q);
        end
        if (count_q != fed_pkg::CountMax) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (en1) begin
        v1_q <= acc;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en_out) begin
        out_v_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      x1_q    <= sample_in_i;
      wp1_q   <= wp_q;
      echo1_q <= echo_now;
    end
    if (en2 && v1_q) begin
      x2_q    <= x1_q;
      wp2_q   <= wp1_q;
      echo2_q <= echo1_q;
      p2_q    <= prod;
    end
    if (wr_en) begin
      out_q <= y;
    end
  end

  assign sample_out_valid_o = out_v_q;
  assign sample_out_o       = out_q;

endmodule
`default_nettype wire

[rtl/fed_checker.sv]
// Port-level checker for the feedback echo delay, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fed_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               sample_in_valid_i,
  input logic                               sample_in_ready_o,
  input logic                               sample_out_valid_o,
  input logic                               sample_out_ready_i,
  input logic signed [fed_pkg::SampleW-1:0] sample_out_o
);

  logic       in_acc, out_acc;
  logic [2:0] cnt_q, cnt_d;

  assign in_acc  = sample_in_valid_i && sample_in_ready_o;
  assign out_acc = sample_out_valid_o && sample_out_ready_i;

  // transactions accepted and not yet delivered
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_out_valid_o && !sample_out_ready_i |=> sample_out_valid_o)
    else $error("output valid dropped before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_out_valid_o && !sample_out_ready_i |=> $stable(sample_out_o))
    else $error("stalled output sample changed");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##3 sample_out_valid_o)
    else $error("no result three cycles after an input transaction");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_out_valid_o |-> (cnt_q != 3'd0))
    else $error("result shown with no sample in flight");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd3)
    else $error("more samples in flight than pipeline stages");

endmodule

bind feedback_echo_delay fed_checker u_fed_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .sample_in_valid_i  (sample_in_valid_i),
  .sample_in_ready_o  (sample_in_ready_o),
  .sample_out_valid_o (sample_out_valid_o),
  .sample_out_ready_i (sample_out_ready_i),
  .sample_out_o       (sample_out_o)
);
`default_nettype wire

[verif/tb_feedback_echo_delay.sv]
// Self-checking testbench for the feedback echo delay: random samples, register phases, stalls.
`timescale 1ns / 1ps
module tb_feedback_echo_delay;

  localparam int unsigned CycleLimit = 200000;

  // Tracks the echo state, predicts each output sample and matches it against the block
  class echo_tracker;
    logic signed [fed_pkg::SampleW-1:0] delay_mem [fed_pkg::MemDepth];
    bit                                 written [fed_pkg::MemDepth];
    int unsigned                        filled;
    fed_pkg::ptr_t                      wr_ptr;
    fed_pkg::ptr_t                      rd_ptr;
    logic [fed_pkg::DelayW-1:0]         count;
    bit                                 echo_on;
    logic [fed_pkg::DecayW-1:0]         decay;
    logic [fed_pkg::DelayW-1:0]         delay;
    logic [fed_pkg::LenW-1:0]           len;
    logic signed [fed_pkg::SampleW-1:0] due_samples [$];
    int unsigned                        faults;

    function new();
      wr_ptr  = '0;
      rd_ptr  = '0;
      count   = '0;
      echo_on = 1'b0;
      filled  = 0;
      faults  = 0;
      decay   = fed_pkg::DecayReset;
      delay   = fed_pkg::DelayReset;
      len     = fed_pkg::LenReset;
    endfunction

    function fed_pkg::ptr_t next_ptr(fed_pkg::ptr_t p);
      int unsigned n;
      int unsigned eff;
      n = p + 1;
      eff = (len > fed_pkg::MemDepth) ? fed_pkg::MemDepth : len;
      if (n >= eff || n >= fed_pkg::MemDepth) n = 0;
      return fed_pkg::ptr_t'(n);
    endfunction

    // A new length must only ever lead the read pointer onto entries already written
    function bit length_is_safe(logic [fed_pkg::LenW-1:0] l);
      int unsigned eff;
      eff = (l > fed_pkg::MemDepth) ? fed_pkg::MemDepth : l;
      if (eff == 0) eff = 1;
      return eff <= filled && (!echo_on || rd_ptr < eff || written[rd_ptr]);
    endfunction

    function void write_reg(fed_pkg::cfg_idx_t idx, logic [fed_pkg::CfgDataW-1:0] data);
      case (idx)
        fed_pkg::CfgDecay:  decay = data[fed_pkg::DecayW-1:0];
        fed_pkg::CfgDelay:  delay = data[fed_pkg::DelayW-1:0];
        fed_pkg::CfgLength: len   = data[fed_pkg::LenW-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [fed_pkg::SampleW-1:0] x);
      logic signed [fed_pkg::SampleW-1:0] y;
      longint g;
      longint s;
      longint mag;
      y = x;
      if (count >= delay) echo_on = 1'b1;
      if (echo_on) begin
        g = (decay > fed_pkg::DecayOne) ? fed_pkg::DecayOne : decay;
        s = (32768 - g) * longint'(x) + g * longint'(delay_mem[rd_ptr]);
        // truncate the magnitude so the result rounds toward zero
        mag = ((s < 0) ? -s : s) >> 15;
        y = fed_pkg::SampleW'((s < 0) ? -mag : mag);
        rd_ptr = next_ptr(rd_ptr);
      end
      delay_mem[wr_ptr] = y;
      written[wr_ptr] = 1'b1;
      while (filled < fed_pkg::MemDepth && written[filled]) filled++;
      wr_ptr = next_ptr(wr_ptr);
      if (count != fed_pkg::CountMax) count++;
      due_samples.push_back(y);
    endfunction

    function void check_sample(logic signed [fed_pkg::SampleW-1:0] y);
      logic signed [fed_pkg::SampleW-1:0] want;
      if (due_samples.size() == 0) begin
        faults++;
        $display("%0t: sample_out unexpected, expected none, got %0d", $time, y);
      end else begin
        want = due_samples.pop_front();
        if (y !== want) begin
          faults++;
          $display("%0t: sample_out mismatch, expected %0d, got %0d", $time, want, y);
        end
      end
    endfunction

    function void report_leftover();
      logic signed [fed_pkg::SampleW-1:0] want;
      while (due_samples.size() != 0) begin
        want = due_samples.pop_front();
        faults++;
        $display("%0t: sample_out missing, expected %0d, got nothing", $time, want);
      end
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  fed_pkg::cfg_idx_t                  cfg_idx = fed_pkg::CfgDecay;
  logic [fed_pkg::CfgDataW-1:0]       cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic signed [fed_pkg::SampleW-1:0] in_sample = '0;
  logic                               out_ready = 1'b0;
  logic                               in_ready;
  logic                               out_valid;
  logic signed [fed_pkg::SampleW-1:0] out_sample;

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_len = 0;
  int unsigned hold_requests = 0;

  echo_tracker tracker;

  feedback_echo_delay uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .sample_in_valid_i (in_valid),
    .sample_in_ready_o (in_ready),
    .sample_in_i       (in_sample),
    .sample_out_valid_o(out_valid),
    .sample_out_ready_i(out_ready),
    .sample_out_o      (out_sample)
  );

  always #4 clk = ~clk;

  // Note inputs before checking outputs so a same-edge transaction pair stays ordered
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready === 1'b1) tracker.note_sample(in_sample);
      if (out_valid === 1'b1 && out_ready) tracker.check_sample(out_sample);
    end
  end

  initial begin : receiver
    int unsigned served;
    int unsigned hold_left;
    served = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_feedback_echo_delay NOT OK");
    $finish;
  end

  task automatic send_sample(input logic signed [fed_pkg::SampleW-1:0] x);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tracker.due_samples.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic poke_reg(input fed_pkg::cfg_idx_t idx,
                          input logic [fed_pkg::CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic apply_settings(input logic [2:0] mask,
                                input logic [fed_pkg::DecayW-1:0] decay_v,
                                input logic [fed_pkg::DelayW-1:0] delay_v,
                                input logic [fed_pkg::LenW-1:0] len_v);
    if (mask[0]) poke_reg(fed_pkg::CfgDecay, fed_pkg::CfgDataW'(decay_v));
    if (mask[1]) poke_reg(fed_pkg::CfgDelay, fed_pkg::CfgDataW'(delay_v));
    if (mask[2]) poke_reg(fed_pkg::CfgLength, fed_pkg::CfgDataW'(len_v));
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned phase;
    logic [fed_pkg::DecayW-1:0] new_decay;
    logic [fed_pkg::DelayW-1:0] new_delay;
    logic [fed_pkg::LenW-1:0] new_len;
    logic [2:0] mask;
    logic signed [fed_pkg::SampleW-1:0] corner_vals [8];
    corner_vals = '{16'sh8000, 16'sh7FFF, 16'sh0000,
      16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA, 16'sh0100};
    tracker = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: long delay, so every sample passes straight through
    foreach (corner_vals[i]) send_sample(corner_vals[i]);
    stop_sending();
    wait_idle();

    // unity decay, longest delay, oversized length: still pass-through
    apply_settings(3'b111, fed_pkg::DecayOne, fed_pkg::CountMax, 16'hFFFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh1234);
    send_sample(16'shEDCB);
    stop_sending();
    wait_idle();

    // echo switches on at once; decay above one saturates, so the delayed value comes back
    apply_settings(3'b111, 16'hFFFF, 20'd1, fed_pkg::LenReset);
    foreach (corner_vals[i]) send_sample(corner_vals[i]);
    stop_sending();
    wait_idle();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 57; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 57; end
        default: begin send_gap_pct = 19; recv_stall_pct = 19; end
      endcase
      case (phase)
        0: new_decay = '0;
        1: new_decay = 16'd16384;
        2: new_decay = fed_pkg::DecayOne;
        3: new_decay = 16'd1;
        4: new_decay = 16'hFFFF;
        5: new_decay = fed_pkg::DecayW'($urandom_range(32768));
        6: new_decay = 16'd24576;
        default: new_decay = fed_pkg::DecayW'($urandom_range(65535));
      endcase
      // length 0 acts as 1; shrinking leaves pointers beyond the new end for one use
      case (phase)
        1: new_len = 16'd1;
        2: new_len = 16'd0;
        3: new_len = fed_pkg::LenW'($urandom_range(tracker.filled, 2));
        4: new_len = 16'd3;
        5: new_len = fed_pkg::LenW'($urandom_range(tracker.filled, 1));
        6: new_len = 16'hFFFF;
        default: new_len = 16'd2;
      endcase
      if (!tracker.length_is_safe(new_len)) new_len = fed_pkg::LenW'(tracker.filled);
      new_delay = fed_pkg::DelayW'($urandom_range(fed_pkg::CountMax, 1));
      // keep the full length in the first phase so the memory fills further
      mask = (phase == 0) ? 3'b011 : 3'b111;
      apply_settings(mask, new_decay, new_delay, new_len);
      if (phase == 0) begin
        hold_len <= 120;
        hold_requests <= hold_requests + 1;
      end
      repeat (50) begin
        case ($urandom_range(7))
          0: send_sample(16'sh8000);
          1: send_sample(16'sh7FFF);
          2: send_sample(16'sh0000);
          3: send_sample(16'shFFFF);
          default: send_sample(fed_pkg::SampleW'($urandom));
        endcase
      end
      stop_sending();
      wait_idle();
    end

    repeat (8) @(posedge clk);
    tracker.report_leftover();
    if (tracker.faults == 0) $display("tb_feedback_echo_delay OK");
    else $display("tb_feedback_echo_delay NOT OK");
    $finish;
  end

endmodule
